>>> src/qfts_pkg.sv
// Package for the queue built from two stacks.
// Holds the transfer item types, the opcode and status codes and the sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package qfts_pkg;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] data_in;
    } req_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] data_out;
        logic               queue_empty;
    } rsp_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOVE,
        S_PUSH,
        S_POP,
        S_RESP
    } state_t;

endpackage

>>> src/queue_from_two_stacks.sv
// First-in first-out queue built from two stacks of DEPTH entries.
// Channel req carries opcode and data_in, channel rsp carries status, data_out and
// queue_empty. Both channels use valid and stall; a transfer completes at a rising
// edge where valid is high and stall is low.
// Each request gives exactly one response. The block works on one request at a
// time and stalls req until the response has been loaded into the output register.
// An enqueue that has room is written to the input stack as the request is taken;
// it and a rejected request go straight to the response state, while a dequeue
// from a non-empty output stack passes through the pop state first.
// When the input stack must be moved across first, the move state reads one entry
// at a time through the single stack read port and writes each read to the output
// stack, and the push or pop state follows before the response state.
// While the receiver stalls, the response register holds its value; the block can
// take one more request and then waits in its response state with req stalled.
// Reset clears both counts, the sequencer and the response valid flag; stack
// contents stay undefined until written and are never read before then.
// Depends on qfts_pkg.
`timescale 1ns / 1ps

module queue_from_two_stacks
    import qfts_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);
    localparam logic [CW-1:0] CNT_ZERO = '0;

    logic signed [31:0] in_mem  [DEPTH];
    logic signed [31:0] out_mem [DEPTH];

    state_t state_reg, state_next;
    logic [CW-1:0] ic_reg, ic_next;
    logic [CW-1:0] oc_reg, oc_next;
    logic pend_reg, pend_next;
    logic op_reg, op_next;
    logic signed [31:0] data_reg, data_next;
    logic [1:0] status_reg, status_next;
    logic rsp_valid_reg, rsp_valid_next;
    rsp_item_t rsp_reg, rsp_next;
    logic signed [31:0] in_rdata_reg;
    logic signed [31:0] out_rdata_reg;

    logic [CW-1:0] ic_m1, oc_m1;
    logic in_full, in_zero, out_zero;
    logic req_take, rsp_load;

    logic          in_we, in_re, out_we, out_re;
    logic [AW-1:0] in_waddr, in_raddr, out_waddr, out_raddr;
    logic signed [31:0] in_wdata;

    assign ic_m1    = ic_reg - CNT_ONE;
    assign oc_m1    = oc_reg - CNT_ONE;
    assign in_full  = (ic_reg == CNT_FULL);
    assign in_zero  = (ic_reg == CNT_ZERO);
    assign out_zero = (oc_reg == CNT_ZERO);
    assign req_take = (state_reg == S_IDLE) && req_valid;
    assign rsp_load = (state_reg == S_RESP) && (!rsp_valid_reg || !rsp_stall);

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (req_valid) begin
                    if (req.opcode == OP_ENQ) begin
                        if (!in_full || !out_zero) begin
                            state_next = S_RESP;
                        end else begin
                            state_next = S_MOVE;
                        end
                    end else begin
                        priority if (!out_zero) begin
                            state_next = S_POP;
                        end else if (!in_zero) begin
                            state_next = S_MOVE;
                        end else begin
                            state_next = S_RESP;
                        end
                    end
                end
            end
            S_MOVE: begin
                if (in_zero && !pend_reg) begin
                    state_next = (op_reg == OP_ENQ) ? S_PUSH : S_POP;
                end
            end
            S_PUSH:  state_next = S_RESP;
            S_POP:   state_next = S_RESP;
            S_RESP: begin
                if (rsp_load) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath control
    always_comb begin
        ic_next     = ic_reg;
        oc_next     = oc_reg;
        pend_next   = 1'b0;
        op_next     = op_reg;
        data_next   = data_reg;
        status_next = status_reg;
        in_we       = 1'b0;
        in_waddr    = ic_reg[AW-1:0];
        in_wdata    = data_reg;
        in_re       = 1'b0;
        in_raddr    = ic_m1[AW-1:0];
        out_we      = 1'b0;
        out_waddr   = oc_reg[AW-1:0];
        out_re      = 1'b0;
        out_raddr   = oc_m1[AW-1:0];
        unique case (state_reg)
            S_IDLE: begin
                if (req_take) begin
                    op_next     = req.opcode;
                    data_next   = req.data_in;
                    status_next = ST_DONE;
                    if (req.opcode == OP_ENQ) begin
                        if (!in_full) begin
                            in_we    = 1'b1;
                            in_wdata = req.data_in;
                            ic_next  = ic_reg + CNT_ONE;
                        end else if (!out_zero) begin
                            status_next = ST_FULL;
                        end
                    end else if (out_zero && in_zero) begin
                        status_next = ST_EMPTY;
                    end
                end
            end
            S_MOVE: begin
                // Read of the input stack top and write of the previous read overlap.
                if (!in_zero) begin
                    in_re     = 1'b1;
                    ic_next   = ic_m1;
                    pend_next = 1'b1;
                end
                if (pend_reg) begin
                    out_we  = 1'b1;
                    oc_next = oc_reg + CNT_ONE;
                end
            end
            S_PUSH: begin
                in_we   = 1'b1;
                ic_next = ic_reg + CNT_ONE;
            end
            S_POP: begin
                out_re  = 1'b1;
                oc_next = oc_m1;
            end
            S_RESP: ;
            default: ;
        endcase
    end

    // Response register
    always_comb begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (rsp_valid_reg && !rsp_stall) begin
            rsp_valid_next = 1'b0;
        end
        if (rsp_load) begin
            rsp_valid_next       = 1'b1;
            rsp_next.status      = status_reg;
            rsp_next.data_out    = (status_reg == ST_DONE && op_reg == OP_DEQ)
                                   ? out_rdata_reg : 32'sd0;
            rsp_next.queue_empty = in_zero && out_zero;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            ic_reg        <= '0;
            oc_reg        <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ic_reg        <= ic_next;
            oc_reg        <= oc_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        op_reg     <= op_next;
        data_reg   <= data_next;
        status_reg <= status_next;
        rsp_reg    <= rsp_next;
    end

    always_ff @(posedge clk) begin
        if (in_we) begin
            in_mem[in_waddr] <= in_wdata;
        end
        if (in_re) begin
            in_rdata_reg <= in_mem[in_raddr];
        end
    end

    always_ff @(posedge clk) begin
        if (out_we) begin
            out_mem[out_waddr] <= in_rdata_reg;
        end
        if (out_re) begin
            out_rdata_reg <= out_mem[out_raddr];
        end
    end

endmodule

>>> src/qfts_checker.sv
// Port-level checks for queue_from_two_stacks, attached by the bind below.
// Depends on qfts_pkg and on the port names of queue_from_two_stacks.
`timescale 1ns / 1ps

module qfts_checker
    import qfts_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_stall,
    input req_item_t req,
    input logic      rsp_valid,
    input logic      rsp_stall,
    input rsp_item_t rsp
);

    // A stalled response stays on the port unchanged.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // Only one request is in work at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while another was in work");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ST_DONE |-> rsp.data_out == 32'sd0)
        else $error("rejected request returned data");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_EMPTY |-> rsp.queue_empty)
        else $error("empty rejection with a non-empty queue");

    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_FULL |-> !rsp.queue_empty)
        else $error("full rejection with an empty queue");

endmodule

bind queue_from_two_stacks qfts_checker u_qfts_checker (.*);

>>> tb/sv/tb_queue_from_two_stacks.sv
// Self-checking testbench for queue_from_two_stacks: a directed table of requests, then a
// long random run of enqueue and dequeue phases; responses checked against model or table.
// Depends on qfts_pkg and queue_from_two_stacks.
`timescale 1ns / 1ps

module tb_queue_from_two_stacks;
    import qfts_pkg::*;

    localparam int DEPTH            = 8;
    localparam int RANDOM_ITEMS     = 650;
    localparam int CALM_ITEMS       = 100;
    localparam int PAUSE_AT         = 400;
    localparam int LONG_HOLD_AT     = 300;
    localparam int LONG_HOLD_CYCLES = 60;
    localparam int SETTLE_CYCLES    = 3 * (DEPTH + 4);
    localparam int LIMIT_NS         = 2_000_000;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    req_item_t req;
    logic      rsp_valid;
    logic      rsp_stall;
    rsp_item_t rsp;

    queue_from_two_stacks #(
        .DEPTH(DEPTH)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

    // Local copy of the two stacks and their fill counts.
    logic [31:0] model_in_stack [DEPTH];
    logic [31:0] model_out_stack [DEPTH];
    int          model_in_count  = 0;
    int          model_out_count = 0;

    rsp_item_t pending_rsp_q [$];

    int mismatches = 0;
    int enq_sent   = 0;
    int deq_sent   = 0;
    int rsp_seen   = 0;
    int done_seen  = 0;
    int full_seen  = 0;
    int empty_seen = 0;
    bit calm       = 1'b0;

    typedef struct {
        logic        opcode;
        logic [31:0] data;
        bit          typed;
        rsp_item_t   want;
    } dir_row_t;

    dir_row_t dir_rows [$];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void model_move_across();
        while (model_in_count > 0 && model_out_count < DEPTH)
        begin
            model_in_count--;
            model_out_stack[model_out_count] = model_in_stack[model_in_count];
            model_out_count++;
        end
    endfunction

    function automatic rsp_item_t model_step(req_item_t item);
        rsp_item_t r;
        r.status   = ST_DONE;
        r.data_out = '0;
        if (item.opcode == OP_ENQ)
        begin
            if (model_in_count >= DEPTH)
            begin
                if (model_out_count == 0)
                    model_move_across();
                else
                    r.status = ST_FULL;
            end
            if (r.status == ST_DONE && model_in_count < DEPTH)
            begin
                model_in_stack[model_in_count] = item.data_in;
                model_in_count++;
            end
        end
        else
        begin
            if (model_out_count == 0)
                model_move_across();
            if (model_out_count == 0)
                r.status = ST_EMPTY;
            else
            begin
                model_out_count--;
                r.data_out = model_out_stack[model_out_count];
            end
        end
        r.queue_empty = (model_in_count == 0 && model_out_count == 0);
        return r;
    endfunction

    function automatic void add_row(logic op, logic [31:0] data, bit typed,
                                    logic [1:0] st, logic [31:0] dout, logic qe);
        dir_row_t row;
        row.opcode           = op;
        row.data             = data;
        row.typed            = typed;
        row.want.status      = st;
        row.want.data_out    = dout;
        row.want.queue_empty = qe;
        dir_rows.push_back(row);
    endfunction

    function automatic void check_rsp(rsp_item_t got);
        rsp_item_t want;
        rsp_seen++;
        if (got.status == ST_DONE)
            done_seen++;
        else if (got.status == ST_FULL)
            full_seen++;
        else if (got.status == ST_EMPTY)
            empty_seen++;
        if (pending_rsp_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: response with none outstanding: status %0d data %h empty %b",
                         $realtime, got.status, got.data_out, got.queue_empty);
            return;
        end
        want = pending_rsp_q.pop_front();
        if (got.status !== want.status || got.data_out !== want.data_out
            || got.queue_empty !== want.queue_empty)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: response %0d: status %0d/%0d data %h/%h empty %b/%b (exp/got)",
                         $realtime, rsp_seen, want.status, got.status, want.data_out,
                         got.data_out, want.queue_empty, got.queue_empty);
        end
    endfunction

    function automatic req_item_t random_req(int mode);
        req_item_t item;
        int        pick;
        pick = $urandom_range(0, 99);
        case (mode)
            0:       item.opcode = (pick < 85) ? OP_ENQ : OP_DEQ;
            1:       item.opcode = (pick < 85) ? OP_DEQ : OP_ENQ;
            default: item.opcode = (pick < 50) ? OP_ENQ : OP_DEQ;
        endcase
        case ($urandom_range(0, 7))
            0:       item.data_in = 32'h7FFF_FFFF;
            1:       item.data_in = 32'h8000_0000;
            2:       item.data_in = 32'h0000_0000;
            3:       item.data_in = 32'hFFFF_FFFF;
            default: item.data_in = $urandom;
        endcase
        return item;
    endfunction

    // Offers one request, with an occasional gap first, and records the expected
    // response once the transfer has taken place.
    task automatic send_req(input req_item_t item, input rsp_item_t typed_want, input bit typed);
        rsp_item_t predicted;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predicted = model_step(item);
        pending_rsp_q.push_back(typed ? typed_want : predicted);
        if (item.opcode == OP_ENQ)
            enq_sent++;
        else
            deq_sent++;
    endtask

    // Receiver: checks each response transfer and decides the stall for the next cycle.
    initial
    begin
        int idle_left;
        bit long_hold_done;
        bit stall_next;
        idle_left      = 0;
        long_hold_done = 1'b0;
        rsp_stall      = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rsp_valid && !rsp_stall)
                check_rsp(rsp);
            if (idle_left > 0)
            begin
                idle_left--;
                stall_next = 1'b1;
            end
            else if (!long_hold_done && rsp_seen >= LONG_HOLD_AT)
            begin
                // Hold off long enough for the block to back up onto its input.
                long_hold_done = 1'b1;
                idle_left      = LONG_HOLD_CYCLES - 1;
                stall_next     = 1'b1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                idle_left  = $urandom_range(0, 7);
                stall_next = 1'b1;
            end
            else
                stall_next = 1'b0;
            rsp_stall <= stall_next;
        end
    end

    initial
    begin
        req_item_t item;
        int        mode;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        mode      = 2;

        // After reset, the extremes, a move across on a full input stack, and a full reject.
        add_row(OP_DEQ, 32'h0000_0000, 1'b1, ST_EMPTY, 32'h0, 1'b1);
        add_row(OP_ENQ, 32'h7FFF_FFFF, 1'b1, ST_DONE, 32'h0, 1'b0);
        add_row(OP_ENQ, 32'h8000_0000, 1'b1, ST_DONE, 32'h0, 1'b0);
        add_row(OP_ENQ, 32'hFFFF_FFFF, 1'b0, ST_DONE, 32'h0, 1'b0);
        add_row(OP_ENQ, 32'h0000_0000, 1'b0, ST_DONE, 32'h0, 1'b0);
        add_row(OP_ENQ, 32'h0000_0001, 1'b0, ST_DONE, 32'h0, 1'b0);
        add_row(OP_ENQ, 32'hAAAA_AAAA, 1'b0, ST_DONE, 32'h0, 1'b0);
        add_row(OP_ENQ, 32'h5555_5555, 1'b0, ST_DONE, 32'h0, 1'b0);
        add_row(OP_ENQ, 32'h1234_5678, 1'b0, ST_DONE, 32'h0, 1'b0);
        add_row(OP_ENQ, 32'hDEAD_BEEF, 1'b0, ST_DONE, 32'h0, 1'b0);
        add_row(OP_DEQ, 32'hFFFF_FFFF, 1'b0, ST_DONE, 32'h0, 1'b0);
        for (int k = 0; k < 7; k++)
            add_row(OP_ENQ, 32'h0100_0000 + k, 1'b0, ST_DONE, 32'h0, 1'b0);
        add_row(OP_ENQ, 32'h0BAD_F00D, 1'b1, ST_FULL, 32'h0, 1'b0);
        add_row(OP_DEQ, 32'h8000_0000, 1'b0, ST_DONE, 32'h0, 1'b0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[k])
        begin
            item.opcode  = dir_rows[k].opcode;
            item.data_in = dir_rows[k].data;
            send_req(item, dir_rows[k].want, dir_rows[k].typed);
        end

        // Random phases bias towards filling, draining or a balanced mix.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 30 == 0)
                mode = $urandom_range(0, 2);
            if (n == RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            if (n == PAUSE_AT && pending_rsp_q.size() != 0)
            begin
                req_valid <= 1'b0;
                while (pending_rsp_q.size() != 0)
                    @(posedge clk);
            end
            send_req(random_req(mode), '0, 1'b0);
        end
        req_valid <= 1'b0;

        while (pending_rsp_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        mismatches += pending_rsp_q.size();

        $display("Sent %0d requests (%0d enqueues, %0d dequeues), checked %0d responses.",
                 enq_sent + deq_sent, enq_sent, deq_sent, rsp_seen);
        $display("Responses: %0d done, %0d full, %0d empty; %0d mismatches.",
                 done_seen, full_seen, empty_seen, mismatches);
        if (mismatches == 0)
            $display("queue_from_two_stacks test passed");
        else
            $display("queue_from_two_stacks test failed");
        $finish;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("queue_from_two_stacks test failed");
        $finish;
    end

endmodule
